### hdl/qpht_pkg.sv
// Package: shared constants and types for the quadratic probe hash table.
package qpht_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned KEY_W = 31;
  localparam int unsigned DATE_W = 32;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W = 2;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd11;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADOPT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ADOPTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, reset probe index
    logic mod_start;  // start reducing current probe address
    logic rd;         // issue slot read at reduced address
    logic step;       // advance probe index
    logic mark_empty; // remember first empty slot seen
    logic wr_insert;  // write new entry at empty slot
    logic wr_adopt;   // write leave date at hit slot
    logic res_load;   // load result register
    logic [STATUS_W-1:0] res_status;
    logic res_use_hit; // result from hit slot
    logic res_use_new; // result from empty slot (insert)
  } qpht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic hit_valid;   // read slot is occupied
    logic hit_match;   // read slot holds the key
    logic hit_adopted;
    logic last_probe;  // probe index reached S-1
    logic over_load;   // 2*occupancy > S
    logic [MODE_W-1:0] mode;
  } qpht_sts_t;

endpackage

### hdl/quadratic_probe_hash_table.sv
// Top level: quadratic probing hash table, controller plus datapath.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  cfg      | cfg_valid, cfg_ready, cfg_data           | in
//  input    | in_valid, in_stall, mode, key, date_word | in
//  result   | out_valid, out_stall, status, slot, ...  | out
//
// Each probe costs one pass of the bit-serial remainder unit (key + i*i mod S)
// plus a read and an evaluate step. The remainder loop sets the rate.
// Reset (synchronous) clears valid/adopted bits and occupancy, table_size to 11.
// A stalled result holds; the controller waits in its final state until the
// result register frees, so an item transfer can complete while a result waits.
module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [KEY_W-1:0]    key,
  input  logic [DATE_W-1:0]   date_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [DATE_W-1:0]   entry_date,
  output logic [DATE_W-1:0]   leave_date,
  output logic                adopted
);

  logic [SIZE_W-1:0] table_size;
  qpht_cmd_t cmd;
  qpht_sts_t sts;
  logic res_full, res_take, busy;

  // config register, writable while no item is being processed
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  assign out_valid = res_full;
  assign res_take = res_full && !out_stall;

  qpht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .res_full(res_full), .res_take(res_take), .sts(sts), .cmd(cmd), .busy(busy)
  );

  qpht_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .table_size(table_size), .mode(mode), .key(key),
    .date_word(date_word), .cmd(cmd), .sts(sts), .res_take(res_take),
    .res_full(res_full), .status(status), .slot(slot), .entry_date(entry_date),
    .leave_date(leave_date), .adopted(adopted)
  );

endmodule

### hdl/qpht_ctrl.sv
// Controller: sequences probes, decisions and result loading.
module qpht_ctrl
  import qpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      res_full,
  input  logic      res_take,
  input  qpht_sts_t sts,
  output qpht_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [STATUS_W-1:0] fin_status, fin_status_next;
  logic fin_hit, fin_hit_next, fin_new, fin_new_next;
  logic fin_ins, fin_ins_next, fin_adp, fin_adp_next;

  // accept when idle; a held result does not block a new item until output
  assign in_stall = (state != S_IDLE);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    fin_status <= fin_status_next;
    fin_hit <= fin_hit_next;
    fin_new <= fin_new_next;
    fin_ins <= fin_ins_next;
    fin_adp <= fin_adp_next;
  end

  always_comb begin
    state_next = state;
    fin_status_next = fin_status;
    fin_hit_next = fin_hit;
    fin_new_next = fin_new;
    fin_ins_next = fin_ins;
    fin_adp_next = fin_adp;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mode == MODE_NONE) begin
          state_next = S_IDLE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.mod_done) begin
          cmd.rd = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        fin_hit_next = 1'b0;
        fin_new_next = 1'b0;
        fin_ins_next = 1'b0;
        fin_adp_next = 1'b0;
        if (sts.hit_valid && sts.hit_match) begin
          fin_hit_next = 1'b1;
          state_next = S_DONE;
          unique case (sts.mode)
            MODE_INSERT: fin_status_next = ST_DUPLICATE;
            MODE_SEARCH: fin_status_next = ST_FOUND;
            default: begin
              if (sts.hit_adopted) begin
                fin_status_next = ST_ALREADY;
              end else begin
                fin_status_next = ST_ADOPTED;
                fin_adp_next = 1'b1;
              end
            end
          endcase
        end else if (!sts.hit_valid || sts.last_probe) begin
          // chain ends at the first empty slot or at the probe limit
          state_next = S_DONE;
          if (sts.mode != MODE_INSERT) begin
            fin_status_next = ST_NOT_FOUND;
          end else if (sts.over_load) begin
            fin_status_next = ST_FULL;
          end else if (!sts.hit_valid) begin
            fin_status_next = ST_INSERTED;
            fin_new_next = 1'b1;
            fin_ins_next = 1'b1;
            cmd.mark_empty = 1'b1;
          end else begin
            fin_status_next = ST_FULL;
          end
        end else begin
          // occupied by another key: next probe
          cmd.step = 1'b1;
          cmd.mod_start = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (!res_full || res_take) begin
          cmd.wr_insert = fin_ins;
          cmd.wr_adopt = fin_adp;
          cmd.res_load = 1'b1;
          cmd.res_status = fin_status;
          cmd.res_use_hit = fin_hit;
          cmd.res_use_new = fin_new;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/qpht_dp.sv
// Datapath: probe address, serial modulo, slot store, result register.
module qpht_dp
  import qpht_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SIZE_W-1:0]   table_size,
  input  logic [MODE_W-1:0]   mode,
  input  logic [KEY_W-1:0]    key,
  input  logic [DATE_W-1:0]   date_word,
  input  qpht_cmd_t           cmd,
  output qpht_sts_t           sts,
  input  logic                res_take,
  output logic                res_full,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [DATE_W-1:0]   entry_date,
  output logic [DATE_W-1:0]   leave_date,
  output logic                adopted
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;        // holds DEPTH
  localparam int unsigned NW = KEY_W + 2 * CW; // key + i*i
  localparam int unsigned BW = $clog2(NW + 1);

  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATE_W-1:0] date_r;
  logic [CW-1:0]     size_eff;
  logic [CW-1:0]     pidx;
  logic [2*CW-1:0]   sq;
  logic [NW-1:0]     num;
  logic [CW-1:0]     rem, rem_sh;
  logic [BW-1:0]     bcnt;
  logic              mod_run;
  logic [AW-1:0]     addr, empty_addr, hit_addr;
  logic              have_empty;
  logic [SIZE_W:0]   occ2;
  logic [SIZE_W-1:0] occupancy;

  logic [DEPTH-1:0]  slot_valid, slot_adopted;
  logic [KEY_W-1:0]  mem_key   [DEPTH];
  logic [DATE_W-1:0] mem_entry [DEPTH];
  logic [DATE_W-1:0] mem_leave [DEPTH];
  logic [KEY_W-1:0]  rd_key;
  logic [DATE_W-1:0] rd_entry, rd_leave;
  logic              rd_valid, rd_adopted;

  always_comb begin
    size_eff = CW'(table_size);
    if (table_size < SIZE_W'(2)) size_eff = CW'(2);
    if (int'(table_size) > int'(DEPTH)) size_eff = CW'(DEPTH);
  end

  // input item and probe index registered; the square is combinational, ahead of the modulo
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      key_r <= key;
      date_r <= date_word;
      pidx <= '0;
    end else if (cmd.step) begin
      pidx <= pidx + 1'b1;
    end
  end
  assign sq = pidx * pidx;

  // restoring remainder, one numerator bit per cycle
  assign rem_sh = {rem[CW-2:0], num[NW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_run <= 1'b0;
    end else if (cmd.mod_start) begin
      mod_run <= 1'b1;
    end else if (mod_run && bcnt == BW'(NW - 1)) begin
      mod_run <= 1'b0;
    end
    if (cmd.mod_start) begin
      num <= NW'(key_r) + NW'(cmd.step ? (pidx + 1'b1) * (pidx + 1'b1) : sq);
      rem <= '0;
      bcnt <= '0;
    end else if (mod_run) begin
      num <= {num[NW-2:0], 1'b0};
      bcnt <= bcnt + 1'b1;
      // rem < size <= 64, so rem_sh < 2*size fits; rem[CW-1] is never set
      rem <= ({1'b0, rem[CW-2:0], num[NW-1]} >= {1'b0, size_eff}) ?
             rem_sh - size_eff : rem_sh;
    end
  end
  assign addr = rem[AW-1:0];

  // slot store
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= mem_key[addr];
      rd_entry <= mem_entry[addr];
      rd_leave <= mem_leave[addr];
      rd_valid <= slot_valid[addr];
      rd_adopted <= slot_adopted[addr];
      hit_addr <= addr;
    end
    if (cmd.wr_insert) begin
      mem_key[empty_addr] <= key_r;
      mem_entry[empty_addr] <= date_r;
    end
    if (cmd.wr_adopt) begin
      mem_leave[hit_addr] <= date_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_adopted <= '0;
      occupancy <= '0;
    end else begin
      if (cmd.wr_insert) begin
        slot_valid[empty_addr] <= 1'b1;
        slot_adopted[empty_addr] <= 1'b0;
        if (occupancy != {SIZE_W{1'b1}}) occupancy <= occupancy + 1'b1;
      end
      if (cmd.wr_adopt) slot_adopted[hit_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      have_empty <= 1'b0;
    end else if (cmd.mark_empty && !have_empty) begin
      have_empty <= 1'b1;
      empty_addr <= hit_addr;
    end
  end

  assign occ2 = {occupancy, 1'b0};
  assign sts.mod_done = !mod_run;
  assign sts.hit_valid = rd_valid;
  assign sts.hit_match = (rd_key == key_r);
  assign sts.hit_adopted = rd_adopted;
  assign sts.last_probe = (pidx == size_eff - 1'b1);
  assign sts.over_load = (int'(occ2) > int'(size_eff));
  assign sts.mode = mode_r;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (cmd.res_load) begin
      res_full <= 1'b1;
    end else if (res_take) begin
      res_full <= 1'b0;
    end
    if (cmd.res_load) begin
      status <= cmd.res_status;
      slot <= '0;
      entry_date <= '0;
      leave_date <= '0;
      adopted <= 1'b0;
      if (cmd.res_use_hit) begin
        slot <= SLOT_W'(hit_addr);
        entry_date <= rd_entry;
        adopted <= rd_adopted || cmd.wr_adopt;
        leave_date <= cmd.wr_adopt ? date_r : (rd_adopted ? rd_leave : '0);
      end else if (cmd.res_use_new) begin
        slot <= SLOT_W'(have_empty ? empty_addr : hit_addr);
        entry_date <= date_r;
      end
    end
  end

endmodule

### sim/tb.sv
// Testbench for quadratic_probe_hash_table: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;
  import qpht_pkg::*;

  localparam int NSLOT = 64;
  localparam int SETTLE = 3200;      // covers the worst item: up to 64 probes
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATE_W-1:0]   entry_date;
    logic [DATE_W-1:0]   leave_date;
    logic                adopted;
  } lookup_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [DATE_W-1:0] date;
    bit                typed;  // want holds a hand-written answer
    lookup_t           want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode = MODE_NONE;
  logic [KEY_W-1:0]    key = '0;
  logic [DATE_W-1:0]   date_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [DATE_W-1:0]   entry_date;
  logic [DATE_W-1:0]   leave_date;
  logic                adopted;

  quadratic_probe_hash_table u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .date_word(date_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .entry_date(entry_date),
    .leave_date(leave_date), .adopted(adopted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the table: slot contents, occupancy and the size register.
  logic                tbl_used    [NSLOT];
  logic [KEY_W-1:0]    tbl_key     [NSLOT];
  logic [DATE_W-1:0]   tbl_entry   [NSLOT];
  logic [DATE_W-1:0]   tbl_leave   [NSLOT];
  logic                tbl_adopted [NSLOT];
  int unsigned         tbl_occ = 0;
  logic [SIZE_W-1:0]   size_reg = TABLE_SIZE_RESET;

  lookup_t     pending_answers[$];
  int unsigned mismatches = 0;
  int unsigned answers_seen = 0;
  int unsigned status_hits[8];
  bit          quiet = 1'b0;       // no gaps on either side while set
  logic [KEY_W-1:0] key_pool[48];

  function automatic lookup_t slot_answer(logic [STATUS_W-1:0] st, int idx);
    lookup_t r;
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      r.slot = idx[SLOT_W-1:0];
      r.entry_date = tbl_entry[idx];
      r.adopted = tbl_adopted[idx];
      r.leave_date = tbl_adopted[idx] ? tbl_leave[idx] : '0;
    end
    return r;
  endfunction

  // Runs one operation on the mirror; returns 0 when no answer is produced.
  function automatic bit probe_table(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                     logic [DATE_W-1:0] d, output lookup_t r);
    longint unsigned s, pos;
    int hit, empty;
    s = size_reg < 2 ? 2 : (size_reg > NSLOT ? NSLOT : size_reg);
    hit = -1;
    empty = -1;
    r = '0;
    if (m == MODE_NONE) return 1'b0;
    // key lookup stops at the first empty slot
    for (longint unsigned i = 0; i < s; i++) begin
      pos = (k + i * i) % s;
      if (!tbl_used[pos]) break;
      if (tbl_key[pos] == k) begin
        hit = int'(pos);
        break;
      end
    end
    if (m == MODE_INSERT) begin
      if (hit >= 0) begin
        r = slot_answer(ST_DUPLICATE, hit);
        return 1'b1;
      end
      if (tbl_occ * 2 > s) begin
        r = slot_answer(ST_FULL, -1);
        return 1'b1;
      end
      for (longint unsigned i = 0; i < s; i++) begin
        pos = (k + i * i) % s;
        if (!tbl_used[pos]) begin
          empty = int'(pos);
          break;
        end
      end
      if (empty < 0) begin
        r = slot_answer(ST_FULL, -1);
        return 1'b1;
      end
      tbl_used[empty] = 1'b1;
      tbl_key[empty] = k;
      tbl_entry[empty] = d;
      tbl_leave[empty] = '0;
      tbl_adopted[empty] = 1'b0;
      if (tbl_occ < 127) tbl_occ++;
      r = slot_answer(ST_INSERTED, empty);
      return 1'b1;
    end
    if (hit < 0) r = slot_answer(ST_NOT_FOUND, -1);
    else if (m == MODE_SEARCH) r = slot_answer(ST_FOUND, hit);
    else if (tbl_adopted[hit]) r = slot_answer(ST_ALREADY, hit);
    else begin
      tbl_leave[hit] = d;
      tbl_adopted[hit] = 1'b1;
      r = slot_answer(ST_ADOPTED, hit);
    end
    return 1'b1;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Result side: compare each transfer with the oldest pending answer.
  always @(posedge clk) begin
    lookup_t w;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      status_hits[status]++;
      if (pending_answers.size() == 0) begin
        report("unexpected result, status", status, 0);
      end else begin
        w = pending_answers.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (slot !== w.slot) report("slot", slot, w.slot);
        if (entry_date !== w.entry_date) report("entry_date", entry_date, w.entry_date);
        if (leave_date !== w.leave_date) report("leave_date", leave_date, w.leave_date);
        if (adopted !== w.adopted) report("adopted", adopted, w.adopted);
      end
    end
  end

  // Receiver stalls: mostly short bursts, now and then a long one.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        hold = $urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transfer on any channel.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else if (++idle_cycles >= WATCH_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic drive_item(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                            logic [DATE_W-1:0] d, bit typed, lookup_t want);
    lookup_t r;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    date_word <= d;
    do @(posedge clk); while (in_stall);
    // transfer taken: update the mirror even when the answer is hand-written
    if (probe_table(m, k, d, r)) pending_answers.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Only while idle; mode-three items leave no answer to wait for.
  task automatic write_size(logic [SIZE_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    size_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t row(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                    logic [DATE_W-1:0] d, bit typed = 0,
                                    lookup_t want = '0);
    plan_row_t p;
    p.mode = m;
    p.key = k;
    p.date = d;
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  plan_row_t plan[$];
  logic [SIZE_W-1:0] phase_sizes[12] =
    '{7'd2, 7'd0, 7'd3, 7'd5, 7'd1, 7'd7, 7'd13, 7'd127, 7'd17, 7'd31, 7'd64, 7'd11};

  initial begin
    lookup_t nil;
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0] k;
    int roll, per_phase;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_used[i] = 1'b0;
      tbl_adopted[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_entry[i] = '0;
      tbl_leave[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
    for (int i = 0; i < 48; i++)
      key_pool[i] = i < 24 ? KEY_W'($urandom_range(0, 300)) : KEY_W'($urandom);

    // Directed part at the reset size of 11.
    nil = '0;
    plan.push_back(row(MODE_SEARCH, 0, 32'h0, 1, '{ST_NOT_FOUND, 0, 0, 0, 0}));
    plan.push_back(row(MODE_INSERT, 0, 32'hFFFF_FFFF, 1,
                       '{ST_INSERTED, 0, 32'hFFFF_FFFF, 0, 0}));
    plan.push_back(row(MODE_INSERT, 0, 32'h0, 1, '{ST_DUPLICATE, 0, 32'hFFFF_FFFF, 0, 0}));
    plan.push_back(row(MODE_SEARCH, 0, 32'h5555_AAAA, 1,
                       '{ST_FOUND, 0, 32'hFFFF_FFFF, 0, 0}));
    plan.push_back(row(MODE_ADOPT, 0, 32'h1234_5678, 1,
                       '{ST_ADOPTED, 0, 32'hFFFF_FFFF, 32'h1234_5678, 1}));
    // second adopt keeps the first leave date
    plan.push_back(row(MODE_ADOPT, 0, 32'h0, 1,
                       '{ST_ALREADY, 0, 32'hFFFF_FFFF, 32'h1234_5678, 1}));
    plan.push_back(row(MODE_INSERT, 31'h7FFF_FFFF, 32'h0));
    plan.push_back(row(MODE_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(row(MODE_ADOPT, 5, 32'hFFFF_FFFF, 1, '{ST_NOT_FOUND, 0, 0, 0, 0}));
    plan.push_back(row(MODE_INSERT, 11, 32'hA5A5_5A5A));   // collides with key 0
    plan.push_back(row(MODE_INSERT, 22, 32'h0000_0001));
    plan.push_back(row(MODE_INSERT, 33, 32'h8000_0000));
    plan.push_back(row(MODE_INSERT, 44, 32'h7FFF_FFFF));
    // six entries in eleven slots: above half load
    plan.push_back(row(MODE_INSERT, 55, 32'h1, 1, '{ST_FULL, 0, 0, 0, 0}));
    plan.push_back(row(MODE_INSERT, 44, 32'h1));            // duplicate wins over full
    plan.push_back(row(MODE_SEARCH, 55, 32'h0));
    plan.push_back(row(MODE_SEARCH, 44, 32'h0));
    plan.push_back(row(MODE_ADOPT, 22, 32'hDEAD_BEEF));
    plan.push_back(row(MODE_SEARCH, 22, 32'h0));
    plan.push_back(row(MODE_SEARCH, 31'h7FFF_FFFF, 32'h0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) drive_item(plan[i].mode, plan[i].key, plan[i].date,
                                 plan[i].typed, plan[i].want);

    // Random part: one phase per table size, extremes included.
    per_phase = 2000 / 12;
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      quiet = (p % 4 == 3);
      for (int n = 0; n < per_phase; n++) begin
        roll = $urandom_range(0, 99);
        m = roll < 40 ? MODE_INSERT : roll < 70 ? MODE_SEARCH :
            roll < 95 ? MODE_ADOPT : MODE_NONE;
        roll = $urandom_range(0, 99);
        k = roll < 65 ? key_pool[$urandom_range(0, 47)] :
            roll < 80 ? KEY_W'($urandom_range(0, 300)) : KEY_W'($urandom);
        drive_item(m, k, $urandom, 0, nil);
        if (p == 5 && n == per_phase / 2) drain_results();  // let the table go idle
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d results over %0d size phases; final occupancy %0d.",
             answers_seen, 1 + $size(phase_sizes), tbl_occ);
    $display("By status: ins %0d fnd %0d nf %0d dup %0d adp %0d again %0d full %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6]);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
